### rtl/core/ctw_pkg.sv
package ctw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CHAR_W     = 8;
  localparam int COLOUR_W   = 4;
  localparam int RROW_W     = 5;
  localparam int RCOL_W     = 7;
  localparam int MODE_W     = 2;
  localparam int S_TDATA_W  = 32;

  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int POS_OUT_W  = 11;
  localparam int CELL_W     = 16;
  localparam int M_TDATA_W  = 40;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] NULL_CODE    = 8'd0;

  localparam int QUEUE_DEPTH = 2;

  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] K_NOP      = 3'd0;
  localparam logic [KIND_W-1:0] K_PUT      = 3'd1;
  localparam logic [KIND_W-1:0] K_NEWLINE  = 3'd2;
  localparam logic [KIND_W-1:0] K_CLEAR    = 3'd3;
  localparam logic [KIND_W-1:0] K_READ     = 3'd4;
  localparam logic [KIND_W-1:0] K_READ_OOB = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CELL_W-1:0] cell_data;
    logic [RROW_W-1:0] rrow;
    logic [RCOL_W-1:0] rcol;
  } cmd_t;

endpackage

### rtl/core/ctw_front.sv
module ctw_front
  import ctw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [MODE_W-1:0]    s_tuser,
  input  logic                 init_done,
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  logic [CHAR_W-1:0]   char_code;
  logic [COLOUR_W-1:0] fore_colour;
  logic [COLOUR_W-1:0] back_colour;
  logic [RROW_W-1:0]   read_row;
  logic [RCOL_W-1:0]   read_col;
  logic                in_range;
  logic                ready;

  assign char_code   = s_tdata[7:0];
  assign fore_colour = s_tdata[11:8];
  assign back_colour = s_tdata[15:12];
  assign read_row    = s_tdata[20:16];
  assign read_col    = s_tdata[27:21];

  assign in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);

  // hold off transactions during the fill after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= 1'b0;
    end else begin
      ready <= init_done;
    end
  end

  assign s_tready = ready && init_done && !q_full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_cmd.cell_data = {back_colour, fore_colour, char_code};
    q_cmd.rrow = read_row;
    q_cmd.rcol = read_col;
    case (s_tuser)
      MODE_PUT: begin
        if (char_code == NULL_CODE) begin
          q_cmd.kind = K_NOP;
        end else if (char_code == NEWLINE_CODE) begin
          q_cmd.kind = K_NEWLINE;
        end else begin
          q_cmd.kind = K_PUT;
        end
      end
      MODE_CLEAR: q_cmd.kind = K_CLEAR;
      MODE_READ:  q_cmd.kind = in_range ? K_READ : K_READ_OOB;
      default:    q_cmd.kind = K_NOP;
    endcase
  end

endmodule

### rtl/core/ctw_queue.sv
module ctw_queue
  import ctw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/ctw_back.sv
module ctw_back
  import ctw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  cmd_t                 head_cmd,
  output logic                 pop,
  output logic                 init_done,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_FILL   = 2'd2;
  localparam logic [1:0] ST_SCROLL = 2'd3;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata;

  logic [1:0]        state;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  top;
  logic [ADDR_W-1:0] fill_cnt;
  logic [ADDR_W-1:0] sweep_base;
  logic [COL_W-1:0]  sweep_cnt;

  logic [COL_OUT_W-1:0] res_col;
  logic [ROW_OUT_W-1:0] res_row;
  logic [POS_OUT_W-1:0] res_pos;
  logic [CELL_W-1:0]    res_cell;
  logic                 res_scrolled;
  logic                 res_load;

  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [ROW_W:0]    top_inc;
  logic              wrap;
  logic              adv;
  logic              over;
  logic [COL_W-1:0]  new_col;
  logic [ROW_W-1:0]  new_row;
  logic [ROW_W-1:0]  top_next;
  logic [COL_W-1:0]  col_sel;
  logic [ROW_W-1:0]  row_sel;
  logic [ADDR_W-1:0] pos_sel;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              is_advance;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] base);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, base};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  assign pop = (state == ST_IDLE) && head_valid && (!m_tvalid || m_tready);

  assign is_advance = (head_cmd.kind == K_PUT) || (head_cmd.kind == K_NEWLINE);

  // cursor advance
  always_comb begin
    col_inc = {1'b0, cur_col} + (COL_W+1)'(1);
    row_inc = {1'b0, cur_row} + (ROW_W+1)'(1);
    top_inc = {1'b0, top} + (ROW_W+1)'(1);
    wrap    = (col_inc >= (COL_W+1)'(COLUMNS));
    if (head_cmd.kind == K_NEWLINE) begin
      adv     = 1'b1;
      new_col = '0;
    end else begin
      adv     = wrap;
      new_col = wrap ? '0 : col_inc[COL_W-1:0];
    end
    over = adv && (row_inc >= (ROW_W+1)'(ROWS));
    if (over) begin
      new_row = ROW_W'(ROWS - 1);
    end else if (adv) begin
      new_row = row_inc[ROW_W-1:0];
    end else begin
      new_row = cur_row;
    end
    top_next = (top_inc >= (ROW_W+1)'(ROWS)) ? '0 : top_inc[ROW_W-1:0];
  end

  always_comb begin
    col_sel = cur_col;
    row_sel = cur_row;
    if (state == ST_IDLE) begin
      if (is_advance) begin
        col_sel = new_col;
        row_sel = new_row;
      end else if (head_cmd.kind == K_CLEAR) begin
        col_sel = '0;
        row_sel = '0;
      end
    end
    pos_sel = ADDR_W'(row_sel * COLUMNS) + ADDR_W'(col_sel);
  end

  assign cur_addr = ADDR_W'(phys_row(cur_row, top) * COLUMNS) + ADDR_W'(cur_col);
  assign raddr = ADDR_W'(phys_row(ROW_W'(head_cmd.rrow), top) * COLUMNS)
               + ADDR_W'(COL_W'(head_cmd.rcol));

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = BLANK_CELL;
    case (state)
      ST_FILL: begin
        we    = 1'b1;
        waddr = fill_cnt;
      end
      ST_SCROLL: begin
        we    = 1'b1;
        waddr = sweep_base + ADDR_W'(sweep_cnt);
      end
      ST_IDLE: begin
        if (pop && (head_cmd.kind == K_PUT)) begin
          we    = 1'b1;
          wdata = head_cmd.cell_data;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      fill_cnt   <= '0;
      init_done  <= 1'b0;
      cur_col    <= '0;
      cur_row    <= '0;
      top        <= '0;
      sweep_cnt  <= '0;
      sweep_base <= '0;
    end else begin
      case (state)
        ST_FILL: begin
          fill_cnt <= fill_cnt + ADDR_W'(1);
          if (fill_cnt == ADDR_W'(CELLS - 1)) begin
            state     <= ST_IDLE;
            init_done <= 1'b1;
          end
        end
        ST_SCROLL: begin
          sweep_cnt <= sweep_cnt + COL_W'(1);
          if (sweep_cnt == COL_W'(COLUMNS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (pop) begin
            case (head_cmd.kind)
              K_PUT, K_NEWLINE: begin
                cur_col <= new_col;
                cur_row <= new_row;
                if (over) begin
                  top        <= top_next;
                  sweep_base <= ADDR_W'(top * COLUMNS);
                  sweep_cnt  <= '0;
                  state      <= ST_SCROLL;
                end
              end
              K_CLEAR: begin
                cur_col  <= '0;
                cur_row  <= '0;
                top      <= '0;
                fill_cnt <= '0;
                state    <= ST_FILL;
              end
              K_READ: state <= ST_READ;
              default: state <= ST_IDLE;
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a result is loaded after a read completes or when any other command pops
  assign res_load = (state == ST_READ) || (pop && (head_cmd.kind != K_READ));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      res_col      <= COL_OUT_W'(col_sel);
      res_row      <= ROW_OUT_W'(row_sel);
      res_pos      <= POS_OUT_W'(pos_sel);
      res_cell     <= rdata;
      res_scrolled <= 1'b0;
    end else if (pop) begin
      res_col      <= COL_OUT_W'(col_sel);
      res_row      <= ROW_OUT_W'(row_sel);
      res_pos      <= POS_OUT_W'(pos_sel);
      res_cell     <= '0;
      res_scrolled <= is_advance && over;
    end
  end

  assign m_tdata = {res_scrolled, res_cell, res_pos, res_row, res_col};

endmodule

### rtl/core/text_console_writer.sv
// text console writer
// a cell store of COLUMNS x ROWS 16-bit cells (char, foreground, background) and a cursor
// input stream s_*: s_tuser carries the mode (put, clear, read), s_tdata the character,
// colours and the read coordinates; every transaction gives exactly one result on m_*
// result stream m_*: cursor column, row and linear position, the read cell and a scroll flag
// a front stage classifies transactions into a two-entry command queue, the back stage
// owns the cursor and the cell memory and works through the queue in order
// results: a put, newline or ignored item passes through the command queue and then the
// registered result fields; a read also passes through the registered memory read port
// throughput: one put per cycle when no scroll occurs and m_tready is high; a scroll blanks
// one row through the single write port while the back stage stays busy; a clear fills
// the whole store before the back stage takes the next command
// scrolling moves a top-row offset, so no cell is copied
// reset: cursor homed; a clearing pass writes blanks to every cell, and s_tready stays
// low until it ends
// a stalled m_tready holds the result; the queue keeps taking transactions until full
module text_console_writer
  import ctw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // char_code[7:0], fore_colour[11:8], back_colour[15:12], read_row[20:16],
  // read_col[27:21], zero[31:28]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]    s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // cursor_col[6:0], cursor_row[11:7], cursor_pos[22:12], cell_value[38:23], scrolled[39]
  output logic [M_TDATA_W-1:0] m_tdata
);

  logic init_done;
  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic head_valid;
  cmd_t head_cmd;

  ctw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  ctw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  ctw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .init_done  (init_done),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
